@@ rtl/tfec_pkg.sv @@
// ---------------------------------------------------------------------------
// tfec_pkg
// Shared codes and reset values for the three floor elevator controller.
// ---------------------------------------------------------------------------
package tfec_pkg;

   // motor drive codes
   typedef enum logic [1:0] {
      DRV_STOP = 2'd0,
      DRV_UP   = 2'd1,
      DRV_DOWN = 2'd2
   } drive_type;

   // decoded serial command codes
   typedef enum logic [2:0] {
      CMD_NONE      = 3'd0,
      CMD_CALL0     = 3'd1,
      CMD_CALL1     = 3'd2,
      CMD_CALL2     = 3'd3,
      CMD_EMERGENCY = 3'd4
   } command_type;

   // first-call preference, none when no end floor is preferred
   localparam logic [1:0] FIRST_NONE = 2'd3;

   // reset values
   localparam logic [7:0] DWELL_TICKS_RESET = 8'd5;
   localparam logic [2:0] BUTTONS_RELEASED  = 3'b111;
   localparam logic [2:0] SENSORS_AT_FLOOR0 = 3'b110;

endpackage

@@ rtl/three_floor_elevator_controller_core.sv @@
// ---------------------------------------------------------------------------
// three_floor_elevator_controller_core
// Polling-step elevator controller: call tracking, stops, dwell, emergency
// and homing to floor 0.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one polling step (active-low buttons and sensors, decoded
//   command, dwell tick). A transaction happens at a clock edge with
//   req_valid high and req_stall low.
//   rsp_* carries the status after that step, one transaction per request.
//   csr_wr_en / csr_wr_data write dwell_ticks; write only while idle.
// Evaluation and throughput:
//   the whole step is evaluated in the cycle of acceptance, and its status
//   is captured in the single result register. One step per clock is
//   sustained while rsp_stall is low.
// Stalls:
//   req_stall is high while a result waits and rsp_stall is high; once the
//   result leaves, a new step is taken in the same cycle.
// Reset:
//   synchronous, active high. The car starts homing down to floor 0, calls
//   clear and dwell_ticks returns to 5.
// ---------------------------------------------------------------------------
module three_floor_elevator_controller_core (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_button_floor0,
   input  logic       req_button_floor1,
   input  logic       req_button_floor2,
   input  logic       req_sensor_floor0,
   input  logic       req_sensor_floor1,
   input  logic       req_sensor_floor2,
   input  logic [2:0] req_command_code,
   input  logic       req_tick,
   // response channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_motor_drive,
   output logic       rsp_horn_on,
   output logic [1:0] rsp_current_floor,
   output logic       rsp_car_stopped,
   output logic       rsp_emergency_active,
   output logic [2:0] rsp_pending_calls,
   output logic       rsp_command_rejected,
   // configuration
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   // state registers
   logic [7:0]                dwell_ticks_ff;
   logic [2:0]                button_hist_ff, button_hist_in;
   logic [2:0]                sensor_hist_ff, sensor_hist_in;
   logic [2:0]                calls_ff,       calls_in;
   logic [1:0]                floor_ff,       floor_in;
   logic [1:0]                first_ff,       first_in;
   logic                      dwell_ff,       dwell_in;
   logic [7:0]                count_ff,       count_in;
   logic                      emerg_ff,       emerg_in;
   logic                      homing_ff,      homing_in;
   tfec_pkg::drive_type       drive_ff,       drive_in;
   logic                      horn_ff,        horn_in;
   logic                      rejected_in;

   // result register
   logic                      rsp_valid_ff;
   logic [1:0]                rsp_drive_ff;
   logic                      rsp_horn_ff;
   logic [1:0]                rsp_floor_ff;
   logic                      rsp_dwell_ff;
   logic                      rsp_emerg_ff;
   logic [2:0]                rsp_calls_ff;
   logic                      rsp_rejected_ff;

   logic                      req_accept;
   logic [2:0]                buttons;
   logic [2:0]                sensors;
   logic [2:0]                bfall;
   logic [2:0]                sfall;
   logic [8:0]                count_next;
   logic                      dwell_done;

   assign buttons = {req_button_floor2, req_button_floor1, req_button_floor0};
   assign sensors = {req_sensor_floor2, req_sensor_floor1, req_sensor_floor0};
   assign bfall   = button_hist_ff & ~buttons;
   assign sfall   = sensor_hist_ff & ~sensors;

   // handshake: stall only while a result waits on a stalled receiver
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // dwell timer end
   assign count_next = {1'b0, count_ff} + 9'd1;
   assign dwell_done = ~homing_ff & req_tick & dwell_ff &
                       (count_next >= {1'b0, dwell_ticks_ff});

   // one polling step
   always_comb begin
      calls_in    = calls_ff;
      floor_in    = floor_ff;
      first_in    = first_ff;
      dwell_in    = dwell_ff;
      count_in    = count_ff;
      emerg_in    = emerg_ff;
      homing_in   = homing_ff;
      drive_in    = drive_ff;
      horn_in     = horn_ff;
      rejected_in = 1'b0;

      // dwell tick
      if (!homing_ff && req_tick && dwell_ff) begin
         if (dwell_done) begin
            dwell_in = 1'b0;
            count_in = '0;
            if (emerg_ff) begin
               homing_in = 1'b1;
               drive_in  = tfec_pkg::DRV_DOWN;
            end
         end else begin
            count_in = count_next[7:0];
         end
      end

      if (homing_in) begin
         // homing ignores buttons, commands and ticks
         drive_in = tfec_pkg::DRV_DOWN;
         if (!sensors[0]) begin
            drive_in  = tfec_pkg::DRV_STOP;
            floor_in  = 2'd0;
            homing_in = 1'b0;
            emerg_in  = 1'b0;
            horn_in   = 1'b0;
         end
      end else begin
         // lowest falling button edge registers a call
         if (bfall[0]) begin
            calls_in[0] = 1'b1;
         end else if (bfall[1]) begin
            calls_in[1] = 1'b1;
         end else if (bfall[2]) begin
            calls_in[2] = 1'b1;
         end

         // command decode
         unique case (req_command_code)
            tfec_pkg::CMD_NONE: begin
            end
            tfec_pkg::CMD_CALL0: begin
               calls_in[0] = 1'b1;
            end
            tfec_pkg::CMD_CALL1: begin
               calls_in[1] = 1'b1;
            end
            tfec_pkg::CMD_CALL2: begin
               calls_in[2] = 1'b1;
            end
            tfec_pkg::CMD_EMERGENCY: begin
               drive_in = tfec_pkg::DRV_STOP;
               horn_in  = 1'b1;
               dwell_in = 1'b1;
               emerg_in = 1'b1;
               calls_in = '0;
            end
            default: begin
               rejected_in = 1'b1;
            end
         endcase

         // first-call preference between the end floors
         if (calls_in[2] && !calls_in[0]) begin
            first_in = 2'd2;
         end else if (calls_in[0] && !calls_in[2]) begin
            first_in = 2'd0;
         end

         // stop at a floor reached with a pending call, higher floor wins
         for (int i = 0; i < 3; i++) begin
            if (sfall[i] && calls_in[i]) begin
               calls_in[i] = 1'b0;
               floor_in    = 2'(i);
               if (first_in == 2'(i)) begin
                  first_in = tfec_pkg::FIRST_NONE;
               end
               drive_in = tfec_pkg::DRV_STOP;
               dwell_in = 1'b1;
            end
         end

         // motor decision
         if (!dwell_in) begin
            case (floor_in)
               2'd0: begin
                  if (calls_in[2:1] != 2'b00) begin
                     drive_in = tfec_pkg::DRV_UP;
                  end
               end
               2'd1: begin
                  if (calls_in[0] || calls_in[2]) begin
                     drive_in = (first_in == 2'd0) ? tfec_pkg::DRV_DOWN
                                                   : tfec_pkg::DRV_UP;
                  end
               end
               2'd2: begin
                  if (calls_in[1:0] != 2'b00) begin
                     drive_in = tfec_pkg::DRV_DOWN;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      button_hist_in = buttons;
      sensor_hist_in = sensors;
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_ticks_ff <= tfec_pkg::DWELL_TICKS_RESET;
      end else if (csr_wr_en) begin
         dwell_ticks_ff <= csr_wr_data;
      end
   end

   // controller state, updated per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         button_hist_ff <= tfec_pkg::BUTTONS_RELEASED;
         sensor_hist_ff <= tfec_pkg::SENSORS_AT_FLOOR0;
         calls_ff       <= '0;
         floor_ff       <= '0;
         first_ff       <= tfec_pkg::FIRST_NONE;
         dwell_ff       <= 1'b0;
         count_ff       <= '0;
         emerg_ff       <= 1'b0;
         homing_ff      <= 1'b1;
         drive_ff       <= tfec_pkg::DRV_DOWN;
         horn_ff        <= 1'b0;
      end else if (req_accept) begin
         button_hist_ff <= button_hist_in;
         sensor_hist_ff <= sensor_hist_in;
         calls_ff       <= calls_in;
         floor_ff       <= floor_in;
         first_ff       <= first_in;
         dwell_ff       <= dwell_in;
         count_ff       <= count_in;
         emerg_ff       <= emerg_in;
         homing_ff      <= homing_in;
         drive_ff       <= drive_in;
         horn_ff        <= horn_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_drive_ff    <= drive_in;
         rsp_horn_ff     <= horn_in;
         rsp_floor_ff    <= floor_in;
         rsp_dwell_ff    <= dwell_in;
         rsp_emerg_ff    <= emerg_in | homing_in;
         rsp_calls_ff    <= calls_in;
         rsp_rejected_ff <= rejected_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_motor_drive      = rsp_drive_ff;
   assign rsp_horn_on          = rsp_horn_ff;
   assign rsp_current_floor    = rsp_floor_ff;
   assign rsp_car_stopped      = rsp_dwell_ff;
   assign rsp_emergency_active = rsp_emerg_ff;
   assign rsp_pending_calls    = rsp_calls_ff;
   assign rsp_command_rejected = rsp_rejected_ff;

   // checks
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted transaction produced no result");

   a_horn_needs_emergency: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_horn_ff) |-> rsp_emerg_ff)
      else $error("horn sounding without emergency");

   a_dwell_means_stopped: assert property (@(posedge clock) disable iff (reset)
      dwell_ff |-> (drive_ff == tfec_pkg::DRV_STOP))
      else $error("car moving while dwelling");

   a_homing_drives_down: assert property (@(posedge clock) disable iff (reset)
      homing_ff |-> (drive_ff == tfec_pkg::DRV_DOWN && !dwell_ff))
      else $error("homing without down drive");

endmodule
